/* src/tasr_pkg.sv */
// shared types and constants for the axis sum reduction block
`default_nettype none

package tasr_pkg;

  localparam int ELEM_W    = 32;   // q16.16 element
  localparam int SUM_W     = 48;   // q32.16 sum
  localparam int OUTER_W   = 16;
  localparam int AXIS_W    = 13;
  localparam int INNER_W   = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 17;   // wide enough for any clamped count
  localparam int Q_DEPTH   = 4;    // front/back decoupling queue, power of two

  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd2;

  // classification of one element, made by the front
  typedef struct packed {
    logic first;   // first slice along the axis: load, do not add
    logic emit;    // last slice along the axis: sum is finished
    logic last;    // final sum of the whole tensor
  } ctl_t;

endpackage

`default_nettype wire

/* src/tasr_ram.sv */
// generic simple dual port ram, read-first, registered read
`default_nettype none

module tasr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/tasr_front.sv */
// front: count registers, tensor position tracking and element classification
`default_nettype none

module tasr_front import tasr_pkg::*; #(
  parameter int MAX_INNER = 1024,
  parameter int MAX_AXIS  = 4096,
  parameter int IW        = 10,
  parameter int AW        = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 in_fire,
  output ctl_t                      push_ctl,
  output logic      [IW-1:0]        push_slot,
  output logic                      at_start
);

  logic [OUTER_W-1:0] outer_cnt_r;
  logic [AXIS_W-1:0]  axis_cnt_r;
  logic [INNER_W-1:0] inner_cnt_r;
  logic [OUTER_W-1:0] outer_pos_r, outer_pos_nxt;
  logic [AW-1:0]      axis_pos_r, axis_pos_nxt;
  logic [IW-1:0]      inner_pos_r, inner_pos_nxt;
  logic [CNT_W-1:0]   n_outer, n_axis, n_inner;
  logic               last_inner, last_axis, last_outer, restart;

  // zero counts act as one, oversize counts are clamped
  always_comb begin
    n_outer = (outer_cnt_r == '0) ? CNT_W'(1) : CNT_W'(outer_cnt_r);
    if (axis_cnt_r == '0) begin
      n_axis = CNT_W'(1);
    end else if (CNT_W'(axis_cnt_r) > CNT_W'(MAX_AXIS)) begin
      n_axis = CNT_W'(MAX_AXIS);
    end else begin
      n_axis = CNT_W'(axis_cnt_r);
    end
    if (inner_cnt_r == '0) begin
      n_inner = CNT_W'(1);
    end else if (CNT_W'(inner_cnt_r) > CNT_W'(MAX_INNER)) begin
      n_inner = CNT_W'(MAX_INNER);
    end else begin
      n_inner = CNT_W'(inner_cnt_r);
    end
  end

  assign last_inner = (CNT_W'(inner_pos_r) + CNT_W'(1)) >= n_inner;
  assign last_axis  = (CNT_W'(axis_pos_r) + CNT_W'(1)) >= n_axis;
  assign last_outer = (CNT_W'(outer_pos_r) + CNT_W'(1)) >= n_outer;

  assign push_ctl.first = (axis_pos_r == '0);
  assign push_ctl.emit  = last_axis;
  assign push_ctl.last  = last_axis && last_inner && last_outer;
  assign push_slot      = inner_pos_r;
  assign at_start       = (outer_pos_r == '0) && (axis_pos_r == '0) && (inner_pos_r == '0);

  assign restart = cfg_we && (cfg_addr == REG_OUTER || cfg_addr == REG_AXIS ||
                              cfg_addr == REG_INNER);

  // nested odometer: inner, then axis, then outer
  always_comb begin
    outer_pos_nxt = outer_pos_r;
    axis_pos_nxt  = axis_pos_r;
    inner_pos_nxt = inner_pos_r;
    if (!last_inner) begin
      inner_pos_nxt = inner_pos_r + IW'(1);
    end else begin
      inner_pos_nxt = '0;
      if (!last_axis) begin
        axis_pos_nxt = axis_pos_r + AW'(1);
      end else begin
        axis_pos_nxt  = '0;
        outer_pos_nxt = last_outer ? '0 : outer_pos_r + OUTER_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_cnt_r <= OUTER_W'(1);
      axis_cnt_r  <= AXIS_W'(1);
      inner_cnt_r <= INNER_W'(1);
      outer_pos_r <= '0;
      axis_pos_r  <= '0;
      inner_pos_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OUTER: outer_cnt_r <= cfg_wdata[OUTER_W-1:0];
          REG_AXIS:  axis_cnt_r  <= cfg_wdata[AXIS_W-1:0];
          REG_INNER: inner_cnt_r <= cfg_wdata[INNER_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        outer_pos_r <= '0;
        axis_pos_r  <= '0;
        inner_pos_r <= '0;
      end else if (in_fire) begin
        outer_pos_r <= outer_pos_nxt;
        axis_pos_r  <= axis_pos_nxt;
        inner_pos_r <= inner_pos_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* src/tasr_queue.sv */
// short fifo between the classifying front and the accumulating back
`default_nettype none

module tasr_queue import tasr_pkg::*; #(
  parameter int W = 45
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  input  wire logic [W-1:0]                   din,
  input  wire logic                           pop,
  output logic      [W-1:0]                   dout,
  output logic                                full,
  output logic                                not_empty,
  output logic      [$clog2(Q_DEPTH+1)-1:0]   cnt
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH+1);

  logic [W-1:0]    ent_r [Q_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = ent_r[rptr_r];
  assign cnt       = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= din;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/tasr_back.sv */
// back: accumulator read-modify-write with forwarding, and the output register
`default_nettype none

module tasr_back import tasr_pkg::*; #(
  parameter int MAX_INNER = 1024,
  parameter int IW        = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire logic [ELEM_W-1:0] q_elem,
  input  wire logic [IW-1:0]     q_slot,
  input  wire ctl_t              q_ctl,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [SUM_W-1:0]  out_sum,
  output logic                   out_last
);

  logic              s1_v_r;
  logic [ELEM_W-1:0] s1_elem_r;
  logic [IW-1:0]     s1_slot_r;
  ctl_t              s1_ctl_r;
  logic              fwd_r, fwd_nxt;
  logic [SUM_W-1:0]  wsum_r;
  logic [SUM_W-1:0]  rd_data, operand, sum;
  logic              out_v_r, out_last_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic              out_free, s1_go, load;

  tasr_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_INNER)
  ) u_acc_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_slot_r),
    .wdata (sum),
    .re    (load),
    .raddr (q_slot),
    .rdata (rd_data)
  );

  // the write of this cycle is not seen by a read of the same cycle: forward it; a first slice adds to zero
  always_comb begin
    if (s1_ctl_r.first) begin
      operand = '0;
    end else if (fwd_r) begin
      operand = wsum_r;
    end else begin
      operand = rd_data;
    end
    sum = operand + {{(SUM_W-ELEM_W){s1_elem_r[ELEM_W-1]}}, s1_elem_r};
  end

  assign out_free = !out_v_r || out_ready;
  assign s1_go    = s1_v_r && (!s1_ctl_r.emit || out_free);
  assign load     = q_valid && (!s1_v_r || s1_go);
  assign q_pop    = load;
  assign fwd_nxt  = s1_go && (s1_slot_r == q_slot);

  always_ff @(posedge clk) begin
    if (load) begin
      s1_elem_r <= q_elem;
      s1_slot_r <= q_slot;
      s1_ctl_r  <= q_ctl;
    end
    if (s1_go) begin
      wsum_r <= sum;
    end
    if (s1_go && s1_ctl_r.emit) begin
      out_sum_r  <= sum;
      out_last_r <= s1_ctl_r.last;
    end
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (load) begin
        s1_v_r <= 1'b1;
        fwd_r  <= fwd_nxt;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
        fwd_r  <= 1'b0;
      end
      if (s1_go && s1_ctl_r.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

/* src/tensor_axis_sum_reduce.sv */
// top level of the tensor axis sum reduction block
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[31:0] element, signed q16.16
//  out_    | out | out_tvalid/out_tready| out_tdata[47:0] sum, signed q32.16; out_tlast
//  cfg_    | in  | cfg_we               | cfg_addr register index, cfg_wdata value
//
// one element per cycle sustained while out_tready keeps the output register free; a request's sum
// passes the queue and the accumulate stage into the output register, which raises out_tvalid
// the rate is set by the single read-modify-write port pair of the accumulator ram
// synchronous active low reset clears counts to one and positions to zero; the
// accumulator ram is not cleared, the first slice along the axis loads it
// out_tready low holds the output register, then the back, then the four-deep
// queue fills and in_tready drops
`default_nettype none

module tensor_axis_sum_reduce import tasr_pkg::*; #(
  parameter int MAX_INNER = 1024,
  parameter int MAX_AXIS  = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // element request channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [31:0]          in_tdata,   // [31:0] element
  // sum channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic      [47:0]          out_tdata,  // [47:0] sum
  output logic                      out_tlast,  // final sum of the tensor
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int AW = (MAX_AXIS > 1) ? $clog2(MAX_AXIS) : 1;
  localparam int QW = ELEM_W + IW + $bits(ctl_t);

  logic                         in_fire;
  ctl_t                         push_ctl, q_ctl;
  logic [IW-1:0]                push_slot, q_slot;
  logic                         at_start;
  logic [QW-1:0]                q_din, q_dout;
  logic [ELEM_W-1:0]            q_elem;
  logic                         q_full, q_valid, q_pop;
  logic [$clog2(Q_DEPTH+1)-1:0] q_cnt;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // front: positions and classification of each request
  tasr_front #(
    .MAX_INNER (MAX_INNER),
    .MAX_AXIS  (MAX_AXIS),
    .IW        (IW),
    .AW        (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .push_ctl  (push_ctl),
    .push_slot (push_slot),
    .at_start  (at_start)
  );

  assign q_din = {in_tdata, push_slot, push_ctl};

  // queue lets the front keep taking requests while the back waits on the output
  tasr_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .din       (q_din),
    .pop       (q_pop),
    .dout      (q_dout),
    .full      (q_full),
    .not_empty (q_valid),
    .cnt       (q_cnt)
  );

  assign {q_elem, q_slot, q_ctl} = q_dout;

  // back: accumulate into the slot and hand finished sums out
  tasr_back #(
    .MAX_INNER (MAX_INNER),
    .IW        (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_elem    (q_elem),
    .q_slot    (q_slot),
    .q_ctl     (q_ctl),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (out_tdata),
    .out_last  (out_tlast)
  );

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= ($clog2(Q_DEPTH+1))'(Q_DEPTH))
    else $error("queue occupancy beyond depth");

  // a tensor-final mark is only given to a finished sum
  a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && push_ctl.last |-> push_ctl.emit)
    else $error("last without emit");

  // a register write restarts the tensor
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_addr == REG_OUTER || cfg_addr == REG_AXIS || cfg_addr == REG_INNER)
    |=> at_start)
    else $error("register write did not restart tensor");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* verif/sum_reduce_checker.sv */
// checker for the axis sum reduction: predicts sums from the element stream and compares them
`timescale 1ns / 1ps

module sum_reduce_checker import tasr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  input  wire logic                 in_tready,
  input  wire logic [31:0]          in_tdata,   // [31:0] element
  input  wire logic                 out_tvalid,
  input  wire logic                 out_tready,
  input  wire logic [47:0]          out_tdata,  // [47:0] sum
  input  wire logic                 out_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output int                        fail_count,
  output int                        pending
);

  localparam int INNER_SLOTS = 1024;
  localparam int AXIS_LIMIT  = 4096;
  localparam int OUTER_LIMIT = 65535;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } axis_sum_t;

  logic [OUTER_W-1:0]      outer_reg;
  logic [AXIS_W-1:0]       axis_reg;
  logic [INNER_W-1:0]      inner_reg;
  int                      outer_idx;
  int                      axis_idx;
  int                      inner_idx;
  logic signed [SUM_W-1:0] partial_sums [INNER_SLOTS];
  axis_sum_t               sum_queue [$];
  int                      mismatches;

  // zero counts behave as one, oversized ones saturate
  function automatic int usable_count(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  task automatic restart_tensor();
    outer_idx = 0;
    axis_idx  = 0;
    inner_idx = 0;
  endtask

  task automatic absorb_element(input logic signed [ELEM_W-1:0] element);
    int        n_outer;
    int        n_axis;
    int        n_inner;
    bit        end_inner;
    bit        end_axis;
    bit        end_outer;
    axis_sum_t done;
    n_outer   = usable_count(int'(outer_reg), OUTER_LIMIT);
    n_axis    = usable_count(int'(axis_reg), AXIS_LIMIT);
    n_inner   = usable_count(int'(inner_reg), INNER_SLOTS);
    end_inner = (inner_idx + 1 >= n_inner);
    end_axis  = (axis_idx + 1 >= n_axis);
    end_outer = (outer_idx + 1 >= n_outer);
    // first slice loads, later slices add
    if (axis_idx == 0)
      partial_sums[inner_idx] = element;
    else
      partial_sums[inner_idx] = partial_sums[inner_idx] + element;
    if (end_axis) begin
      done.sum  = partial_sums[inner_idx];
      done.last = end_inner && end_outer;
      sum_queue.push_back(done);
    end
    if (!end_inner) begin
      inner_idx++;
    end else begin
      inner_idx = 0;
      if (!end_axis) begin
        axis_idx++;
      end else begin
        axis_idx = 0;
        outer_idx = end_outer ? 0 : outer_idx + 1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    axis_sum_t want;
    if (!rst_n) begin
      outer_reg = OUTER_W'(1);
      axis_reg  = AXIS_W'(1);
      inner_reg = INNER_W'(1);
      restart_tensor();
      sum_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OUTER: begin
            outer_reg = cfg_wdata[OUTER_W-1:0];
            restart_tensor();
          end
          REG_AXIS: begin
            axis_reg = cfg_wdata[AXIS_W-1:0];
            restart_tensor();
          end
          REG_INNER: begin
            inner_reg = cfg_wdata[INNER_W-1:0];
            restart_tensor();
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        absorb_element(in_tdata);
      if (out_tvalid && out_tready) begin
        if (sum_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sum %0d last %0b", $signed(out_tdata), out_tlast);
        end else begin
          want = sum_queue.pop_front();
          if (out_tdata !== want.sum || out_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sum mismatch: expected %0d last %0b, got %0d last %0b",
                       want.sum, want.last, $signed(out_tdata), out_tlast);
          end
        end
      end
    end
    pending    <= sum_queue.size();
    fail_count <= mismatches;
  end

endmodule

/* verif/tensor_axis_sum_reduce_test.sv */
// stimulus and verdict for the tensor axis sum reduction block
`timescale 1ns / 1ps

module tensor_axis_sum_reduce_test;
  import tasr_pkg::*;

  // unmapped register index: a write there must leave the tensor untouched
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // element value styles, chosen per phase
  typedef enum int {
    ELEM_ANY,
    ELEM_TOP,
    ELEM_BOTTOM,
    ELEM_TINY,
    ELEM_EDGES
  } elem_mix_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [31:0]          in_tdata;    // [31:0] element
  logic                 out_tvalid;
  logic                 out_tready;
  logic [47:0]          out_tdata;   // [47:0] sum
  logic                 out_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;

  int fails;
  int pending;
  int items_sent;
  bit no_idle;     // phase-wide switch: both sides run back to back

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  tensor_axis_sum_reduce DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // prediction and comparison live in the checker; this module only drives
  sum_reduce_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fails),
    .pending    (pending)
  );

  // generous limit, several times the slowest legal run
  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: a fresh stall length for every sum, ready held until it is taken
  initial begin : sum_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  function automatic logic [31:0] pick_element(input elem_mix_t mix);
    case (mix)
      ELEM_TOP:    return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      ELEM_BOTTOM: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      // within one unit of zero in q16.16
      ELEM_TINY:   return 32'($urandom_range(0, 131072)) - 32'd65536;
      ELEM_EDGES: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      default:     return $urandom;
    endcase
  endfunction

  // one element request; entered and left just after a rising edge
  task automatic send_element(input logic [31:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // drain: every predicted sum delivered, then allow for a trailing element
  // that makes no sum but may still be inside the pipeline
  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // drives one write; the caller drops cfg_we after the last of a batch
  task automatic write_one(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // all three counts, in a rotated order, sometimes with a stray write first
  task automatic configure(input int outer_v, input int axis_v, input int inner_v);
    logic [CFG_IDX_W-1:0] addr [3];
    int                   value [3];
    int                   start;
    addr  = '{REG_OUTER, REG_AXIS, REG_INNER};
    value = '{outer_v, axis_v, inner_v};
    start = $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) write_one(REG_NONE, CFG_W'($urandom));
    for (int k = 0; k < 3; k++)
      write_one(addr[(start + k) % 3], CFG_W'(value[(start + k) % 3]));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int outer_v, input int axis_v, input int inner_v,
                           input int count, input elem_mix_t mix);
    quiesce();
    configure(outer_v, axis_v, inner_v);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat (count) send_element(pick_element(mix));
  endtask

  initial begin : stimulus
    int        o_n;
    int        a_n;
    int        i_n;
    int        total;
    int        target;
    bit        big;
    elem_mix_t mix;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_OUTER;
    cfg_wdata <= '0;
    no_idle    = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset counts are all one: every element is its own finished tensor
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0001_0000);
    send_element(32'h0000_0001);
    send_element(32'hFFFF_0000);

    // zero counts fall back to one
    run_phase(0, 0, 0, 2, ELEM_EDGES);

    // small 2x3x2 tensor, interrupted halfway by a write to the unmapped index;
    // the tensor must carry on, then wrap into a new one by one element
    run_phase(2, 3, 2, 6, ELEM_EDGES);
    quiesce();
    write_one(REG_NONE, 16'hFFFF);
    cfg_we <= 1'b0;
    repeat (7) send_element(pick_element(ELEM_EDGES));

    // size corners, cut short where a whole tensor would be too long
    run_phase(65535, 1, 1, 40, ELEM_ANY);          // outer count at its top, never ends
    run_phase(1, 16'hFFFF, 1, 200, ELEM_TOP);      // axis masked then capped, no early sum
    run_phase(1, 256, 1, 256, ELEM_BOTTOM);        // deep axis, sum far beyond 32 bits
    run_phase(1, 200, 1, 200, ELEM_TOP);           // large positive sum
    run_phase(1, 1, 16'hFFFF, 200, ELEM_ANY);      // inner masked then capped
    run_phase(1, 2, 160, 200, ELEM_EDGES);         // slots loaded then added, cut short

    // random tensors: mostly small and complete, some larger, some cut short
    target = 1650;
    while (items_sent < target) begin
      big   = ($urandom_range(0, 7) == 0);
      o_n   = big ? 1 : $urandom_range(1, 3);
      a_n   = big ? $urandom_range(1, 40) : $urandom_range(1, 6);
      i_n   = big ? $urandom_range(1, 40) : $urandom_range(1, 6);
      total = o_n * a_n * i_n * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) total = $urandom_range(0, total - 1);
      if (total > target - items_sent) total = target - items_sent;
      mix = elem_mix_t'($urandom_range(0, 4));
      run_phase(o_n, a_n, i_n, total, mix);
    end

    quiesce();
    if (fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
src/tasr_pkg.sv
src/tasr_ram.sv
src/tasr_front.sv
src/tasr_queue.sv
src/tasr_back.sv
src/tensor_axis_sum_reduce.sv
verif/sum_reduce_checker.sv
verif/tensor_axis_sum_reduce_test.sv
